// ===== src/bgr_pkg.sv =====
// ---------------------------------------------------------------------------
// bgr_pkg: shared types and helpers for the Brusselator grid RHS core
// Grid geometry, window slot arithmetic, payload structs and saturation.
// ---------------------------------------------------------------------------
package bgr_pkg;

    // Grid and window geometry
    localparam int GRID_SIDE = 32;
    localparam int WIN_DEPTH = 2 * GRID_SIDE + 1;
    localparam int SLOT_W    = $clog2(WIN_DEPTH);
    localparam int POS_W     = $clog2(GRID_SIDE);
    localparam int OFF_W     = SLOT_W + 2;
    localparam int CELL_W    = 5;
    localparam int DATA_W    = 32;

    // Laplacian scale (G-1)^2 and intermediate widths
    localparam int LAP_SCALE = (GRID_SIDE - 1) * (GRID_SIDE - 1);
    localparam int SCALE_W   = $clog2(LAP_SCALE + 1) + 1;
    localparam int SUM_W     = DATA_W + 3;
    localparam int LAP_W     = DATA_W + 4;
    localparam int TERM_W    = DATA_W + 2;

    // Front queue depth (power of two)
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam int CFG_IDX_W = 2;

    localparam logic signed [OFF_W-1:0] OFF_ONE  = OFF_W'(1);
    localparam logic signed [OFF_W-1:0] OFF_G    = OFF_W'(GRID_SIDE);
    localparam logic signed [OFF_W-1:0] DEPTH_S  = OFF_W'(WIN_DEPTH);
    localparam logic [POS_W-1:0]        POS_LAST = POS_W'(GRID_SIDE - 1);

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEED  = 2'd0,
        REG_DECAY = 2'd1,
        REG_CONV  = 2'd2,
        REG_DIFF  = 2'd3
    } reg_idx_t;

    // Result release bits carried with each queued item
    localparam int EMIT_ABOVE = 0;
    localparam int EMIT_LEFT  = 1;
    localparam int EMIT_SELF  = 2;
    localparam int MASK_W     = 3;

    // Neighbor read order
    localparam logic [2:0] NB_CTR   = 3'd0;
    localparam logic [2:0] NB_LEFT  = 3'd1;
    localparam logic [2:0] NB_RIGHT = 3'd2;
    localparam logic [2:0] NB_UP    = 3'd3;
    localparam logic [2:0] NB_DOWN  = 3'd4;
    localparam logic [2:0] NB_DONE  = 3'd5;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NEXT,
        B_READ,
        B_LAP,
        B_MUL,
        B_SUM
    } back_state_t;

    typedef enum logic [2:0] {
        M_UU,
        M_UUV,
        M_DLIN,
        M_CLIN,
        M_DDIF,
        M_VDIF
    } mul_step_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] u_in;
        logic signed [DATA_W-1:0] v_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] du_out;
        logic signed [DATA_W-1:0] dv_out;
        logic [CELL_W-1:0]        cell_row;
        logic [CELL_W-1:0]        cell_col;
        logic                     frame_end;
        logic                     run_last;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] feed;
        logic signed [DATA_W-1:0] decay;
        logic signed [DATA_W-1:0] conv;
        logic signed [DATA_W-1:0] diff;
    } cfg_regs_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic [SLOT_W-1:0]        slot;
        logic [MASK_W-1:0]        mask;
    } q_item_t;

    typedef struct packed {
        logic                  we;
        logic [SLOT_W-1:0]     addr;
        logic [2*DATA_W-1:0]   data;
    } ram_wr_t;

    // Clamp to signed 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x;
        if (t > SAT_MAX) t = SAT_MAX;
        else if (t < SAT_MIN) t = SAT_MIN;
        return t[DATA_W-1:0];
    endfunction

    // Window slot plus a small signed offset, modulo the window depth
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                   input logic signed [OFF_W-1:0] off);
        logic signed [OFF_W-1:0] t;
        t = signed'(OFF_W'(s)) + off;
        if (t < 0) t = t + DEPTH_S;
        else if (t >= DEPTH_S) t = t - DEPTH_S;
        return t[SLOT_W-1:0];
    endfunction

endpackage

// ===== src/bgr_ram.sv =====
// ---------------------------------------------------------------------------
// bgr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bgr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bgr_front.sv =====
// ---------------------------------------------------------------------------
// bgr_front: input acceptance and classification
// Tracks raster position and window slot, tags each item with the results it
// releases, and buffers it in a short queue for the back end.
// ---------------------------------------------------------------------------
module bgr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bgr_pkg::in_item_t  in_item,
    output logic               q_valid,
    input  logic               q_pop,
    output bgr_pkg::q_item_t   q_item
);
    import bgr_pkg::*;

    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    q_item_t           fifo_mem [QDEPTH];
    q_item_t           new_item;
    logic              accept;
    logic              last_row;
    logic              last_col;

    assign in_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign accept   = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_mem[rd_ptr_reg];
    assign last_row = (row_reg == POS_LAST);
    assign last_col = (col_reg == POS_LAST);

    // Classify the item by the results it releases
    always_comb
    begin
        new_item                 = '0;
        new_item.u               = in_item.u_in;
        new_item.v               = in_item.v_in;
        new_item.row             = row_reg;
        new_item.col             = col_reg;
        new_item.slot            = slot_reg;
        new_item.mask[EMIT_ABOVE] = (row_reg != '0);
        new_item.mask[EMIT_LEFT]  = last_row && (col_reg != '0);
        new_item.mask[EMIT_SELF]  = last_row && last_col;
    end

    // Advance position; slot restarts with each frame
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            if (last_row && last_col)
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_add(slot_reg, OFF_ONE);
            end
        end
    end

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(accept) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            slot_reg   <= slot_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fifo_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== src/bgr_back.sv =====
// ---------------------------------------------------------------------------
// bgr_back: window update, stencil gather and reaction arithmetic
// Writes each item into the window, then for every released cell reads the
// five stencil points, forms both Laplacians and runs the products through
// one shared multiplier before loading the output register.
// ---------------------------------------------------------------------------
module bgr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  bgr_pkg::q_item_t                  q_item,
    input  bgr_pkg::cfg_regs_t                cfg,
    output bgr_pkg::ram_wr_t                  ram_wr,
    output logic [bgr_pkg::SLOT_W-1:0]        ram_raddr,
    input  logic [2*bgr_pkg::DATA_W-1:0]      ram_rdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bgr_pkg::out_item_t                out_item
);
    import bgr_pkg::*;

    localparam logic signed [SCALE_W-1:0] LAP_SCALE_S = SCALE_W'(LAP_SCALE);

    back_state_t state_reg, state_next;
    mul_step_t   mstep_reg, mstep_next;
    logic [2:0]  rd_idx_reg, rd_idx_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic        out_valid_reg, out_valid_next;

    // Item and cell context
    logic [POS_W-1:0]  row_reg, col_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [POS_W-1:0]  cell_row_reg, cell_col_reg;
    logic [SLOT_W-1:0] cell_slot_reg;
    logic              last_reg;

    // Gathered stencil values
    logic signed [DATA_W-1:0] u_ctr_reg, v_ctr_reg;
    logic signed [SUM_W-1:0]  u_sum_reg, v_sum_reg;
    logic signed [DATA_W-1:0] lapu_reg, lapv_reg;

    // Products
    logic signed [DATA_W-1:0] uu_reg, uuv_reg, dlin_reg, clin_reg, ddif_reg, vdif_reg;
    out_item_t                out_reg;

    // Combinational
    logic [POS_W-1:0]  sel_row, sel_col;
    logic [SLOT_W-1:0] sel_slot;
    logic [MASK_W-1:0] sel_rest;
    logic [2:0]        rd_prev;
    logic signed [DATA_W-1:0] rd_u, rd_v;
    logic signed [LAP_W-1:0]  lap_u, lap_v;
    logic signed [LAP_W+SCALE_W-1:0] lap_u_s, lap_v_s;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [63:0]       mul_p;
    logic signed [DATA_W-1:0] mul_q;
    logic signed [TERM_W-1:0] du_w, dv_w;
    logic        out_load;

    assign rd_u    = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_v    = ram_rdata[DATA_W-1:0];
    assign rd_prev = rd_idx_reg - 3'd1;

    // Pick the next released cell: above row first, then left, then itself
    always_comb
    begin
        sel_row  = row_reg;
        sel_col  = col_reg;
        sel_slot = slot_reg;
        sel_rest = mask_reg;
        if (mask_reg[EMIT_ABOVE])
        begin
            sel_row              = row_reg - 1'b1;
            sel_slot             = slot_add(slot_reg, -OFF_G);
            sel_rest[EMIT_ABOVE] = 1'b0;
        end
        else if (mask_reg[EMIT_LEFT])
        begin
            sel_col             = col_reg - 1'b1;
            sel_slot            = slot_add(slot_reg, -OFF_ONE);
            sel_rest[EMIT_LEFT] = 1'b0;
        end
        else
        begin
            sel_rest[EMIT_SELF] = 1'b0;
        end
    end

    // Neighbor address with mirrored edges
    always_comb
    begin
        case (rd_idx_reg)
            NB_CTR:   ram_raddr = cell_slot_reg;
            NB_LEFT:  ram_raddr = slot_add(cell_slot_reg,
                                           (cell_col_reg == '0) ? OFF_ONE : -OFF_ONE);
            NB_RIGHT: ram_raddr = slot_add(cell_slot_reg,
                                           (cell_col_reg == POS_LAST) ? -OFF_ONE : OFF_ONE);
            NB_UP:    ram_raddr = slot_add(cell_slot_reg,
                                           (cell_row_reg == '0) ? OFF_G : -OFF_G);
            NB_DOWN:  ram_raddr = slot_add(cell_slot_reg,
                                           (cell_row_reg == POS_LAST) ? -OFF_G : OFF_G);
            default:  ram_raddr = cell_slot_reg;
        endcase
    end

    // Laplacians scaled by (G-1)^2
    always_comb
    begin
        lap_u   = LAP_W'(u_sum_reg) - (LAP_W'(u_ctr_reg) <<< 2);
        lap_v   = LAP_W'(v_sum_reg) - (LAP_W'(v_ctr_reg) <<< 2);
        lap_u_s = lap_u * LAP_SCALE_S;
        lap_v_s = lap_v * LAP_SCALE_S;
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (mstep_reg)
            M_UU:    begin mul_a = u_ctr_reg; mul_b = u_ctr_reg; end
            M_UUV:   begin mul_a = uu_reg;    mul_b = v_ctr_reg; end
            M_DLIN:  begin mul_a = cfg.decay; mul_b = u_ctr_reg; end
            M_CLIN:  begin mul_a = cfg.conv;  mul_b = u_ctr_reg; end
            M_DDIF:  begin mul_a = cfg.diff;  mul_b = lapu_reg;  end
            M_VDIF:  begin mul_a = cfg.diff;  mul_b = lapv_reg;  end
            default: begin mul_a = u_ctr_reg; mul_b = u_ctr_reg; end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
        mul_q = sat32(mul_p >>> 16);
    end

    // Final sums
    always_comb
    begin
        du_w = TERM_W'(cfg.feed) + TERM_W'(uuv_reg) - TERM_W'(dlin_reg) + TERM_W'(ddif_reg);
        dv_w = TERM_W'(clin_reg) - TERM_W'(uuv_reg) + TERM_W'(vdif_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (q_valid) state_next = B_NEXT;
            B_NEXT: state_next = (mask_reg == '0) ? B_IDLE : B_READ;
            B_READ: if (rd_idx_reg == NB_DONE) state_next = B_LAP;
            B_LAP:  state_next = B_MUL;
            B_MUL:  if (mstep_reg == M_VDIF) state_next = B_SUM;
            B_SUM:  if (out_load) state_next = B_NEXT;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop       = (state_reg == B_IDLE) && q_valid;
        ram_wr.we   = q_pop;
        ram_wr.addr = q_item.slot;
        ram_wr.data = {q_item.u, q_item.v};
        out_load    = (state_reg == B_SUM) && (!out_valid_reg || out_ready);
    end

    // Control counters and mask
    always_comb
    begin
        mask_next      = mask_reg;
        rd_idx_next    = rd_idx_reg;
        mstep_next     = mstep_reg;
        out_valid_next = out_load || (out_valid_reg && !out_ready);
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid) mask_next = q_item.mask;
            end
            B_NEXT:
            begin
                mask_next   = sel_rest;
                rd_idx_next = NB_CTR;
            end
            B_READ:
            begin
                rd_idx_next = rd_idx_reg + 3'd1;
                mstep_next  = M_UU;
            end
            B_MUL:
            begin
                if (mstep_reg != M_VDIF) mstep_next = mul_step_t'(mstep_reg + 3'd1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            mstep_reg     <= M_UU;
            rd_idx_reg    <= NB_CTR;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            rd_idx_reg    <= rd_idx_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    row_reg  <= q_item.row;
                    col_reg  <= q_item.col;
                    slot_reg <= q_item.slot;
                end
            end
            B_NEXT:
            begin
                cell_row_reg  <= sel_row;
                cell_col_reg  <= sel_col;
                cell_slot_reg <= sel_slot;
                last_reg      <= (sel_rest == '0);
                u_sum_reg     <= '0;
                v_sum_reg     <= '0;
            end
            B_READ:
            begin
                // Absorb read data of the previous address
                if (rd_idx_reg != NB_CTR)
                begin
                    if (rd_prev == NB_CTR)
                    begin
                        u_ctr_reg <= rd_u;
                        v_ctr_reg <= rd_v;
                    end
                    else
                    begin
                        u_sum_reg <= u_sum_reg + SUM_W'(rd_u);
                        v_sum_reg <= v_sum_reg + SUM_W'(rd_v);
                    end
                end
            end
            B_LAP:
            begin
                lapu_reg <= sat32(64'(lap_u_s));
                lapv_reg <= sat32(64'(lap_v_s));
            end
            B_MUL:
            begin
                case (mstep_reg)
                    M_UU:    uu_reg   <= mul_q;
                    M_UUV:   uuv_reg  <= mul_q;
                    M_DLIN:  dlin_reg <= mul_q;
                    M_CLIN:  clin_reg <= mul_q;
                    M_DDIF:  ddif_reg <= mul_q;
                    M_VDIF:  vdif_reg <= mul_q;
                    default: uu_reg   <= mul_q;
                endcase
            end
            B_SUM:
            begin
                if (out_load)
                begin
                    out_reg.du_out    <= sat32(64'(du_w));
                    out_reg.dv_out    <= sat32(64'(dv_w));
                    out_reg.cell_row  <= CELL_W'(cell_row_reg);
                    out_reg.cell_col  <= CELL_W'(cell_col_reg);
                    out_reg.frame_end <= (cell_row_reg == POS_LAST) &&
                                         (cell_col_reg == POS_LAST);
                    out_reg.run_last  <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== src/brusselator_grid_rhs_core.sv =====
// A first-row item releases no result; any other item releases 1 to 3 cells, each of which
// is paced by the single RAM read port (five stencil reads) and the one shared multiplier.
// A two-entry queue lets input acceptance run ahead of the arithmetic.
// Reset clears position, queue, sequencer and output valid, and sets all rates to 1.0.
// ---------------------------------------------------------------------------
// brusselator_grid_rhs_core: Brusselator reaction-diffusion RHS over a grid
// Streams raster cells in, keeps a window of two rows plus one cell in RAM and
// emits du, dv for each cell once its lower neighbor is present.
// ---------------------------------------------------------------------------
module brusselator_grid_rhs_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bgr_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bgr_pkg::out_item_t              out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgr_pkg::DATA_W-1:0]      cfg_data
);
    import bgr_pkg::*;

    cfg_regs_t           cfg_reg, cfg_next;
    logic                q_valid;
    logic                q_pop;
    q_item_t             q_item;
    ram_wr_t             ram_wr;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [2*DATA_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FEED:  cfg_next.feed  = cfg_data;
                REG_DECAY: cfg_next.decay = cfg_data;
                REG_CONV:  cfg_next.conv  = cfg_data;
                REG_DIFF:  cfg_next.diff  = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feed  <= 32'sd65536;
            cfg_reg.decay <= 32'sd65536;
            cfg_reg.conv  <= 32'sd65536;
            cfg_reg.diff  <= 32'sd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bgr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    bgr_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg       (cfg_reg),
        .ram_wr    (ram_wr),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== src/bgr_checker.sv =====
// ---------------------------------------------------------------------------
// bgr_checker: port-level checks for the grid RHS core
// Watches the handshakes and the frame markers on the result stream.
// ---------------------------------------------------------------------------
module bgr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  bgr_pkg::in_item_t               in_item,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  bgr_pkg::out_item_t              out_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);
    import bgr_pkg::*;

    // Stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item changed while stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Frame end marks the corner cell and closes its run
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.frame_end |->
            out_item.run_last &&
            out_item.cell_row == CELL_W'(GRID_SIDE - 1) &&
            out_item.cell_col == CELL_W'(GRID_SIDE - 1))
        else $error("frame end on wrong cell");

    // A result right after an accepted frame end must be at column zero
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_item.frame_end ##1 out_valid |->
            out_item.cell_col == '0)
        else $error("frame did not restart at column zero");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind brusselator_grid_rhs_core bgr_checker u_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: regression bench for the Brusselator grid RHS core
// Streams raster cells through several coefficient settings, predicts du/dv
// for every released cell and checks each result item in order.
// ---------------------------------------------------------------------------
module tb;
    import bgr_pkg::*;

    localparam int  NUM_PHASES = 6;
    localparam int  RAND_ITEMS = 51;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  HOLD_LEN   = 500;
    localparam int  HOLD_AT    = 150;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]  cfg_data;

    // Pending stimulus and expected results
    in_item_t           cell_q[$];
    out_item_t          rhs_q[$];

    // Predictor state
    longint             m_feed, m_decay, m_conv, m_diff;
    longint             u_win[WIN_DEPTH];
    longint             v_win[WIN_DEPTH];
    int                 m_row, m_col;

    int                 in_gap;
    int                 out_stall;
    int                 hold_left;
    bit                 hold_done;
    bit                 fast_mode;
    int                 cells_sent;
    int                 results_seen;
    int                 frames_seen;
    int                 err_count;
    int                 idle_cycles;

    brusselator_grid_rhs_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic int win_slot(input int r, input int c);
        return (r * GRID_SIDE + c) % WIN_DEPTH;
    endfunction

    // Scaled five-point Laplacian with mirrored edges
    function automatic longint stencil(input bit use_v, input int r, input int c);
        int     up, dn, lf, rt;
        longint ctr, sum;
        up  = (r == 0) ? r + 1 : r - 1;
        dn  = (r == GRID_SIDE - 1) ? r - 1 : r + 1;
        lf  = (c == 0) ? c + 1 : c - 1;
        rt  = (c == GRID_SIDE - 1) ? c - 1 : c + 1;
        if (use_v)
        begin
            ctr = v_win[win_slot(r, c)];
            sum = v_win[win_slot(r, rt)] + v_win[win_slot(r, lf)] - 2 * ctr
                + v_win[win_slot(up, c)] + v_win[win_slot(dn, c)] - 2 * ctr;
        end
        else
        begin
            ctr = u_win[win_slot(r, c)];
            sum = u_win[win_slot(r, rt)] + u_win[win_slot(r, lf)] - 2 * ctr
                + u_win[win_slot(up, c)] + u_win[win_slot(dn, c)] - 2 * ctr;
        end
        return clamp32(sum * LAP_SCALE);
    endfunction

    // Compute du/dv of one cell from the window
    function automatic out_item_t cell_rhs(input int r, input int c);
        out_item_t res;
        longint    u, v, uu, uuv, dlin, clin, udif, vdif;
        u    = u_win[win_slot(r, c)];
        v    = v_win[win_slot(r, c)];
        uu   = clamp32((u * u) >>> 16);
        uuv  = clamp32((uu * v) >>> 16);
        dlin = clamp32((m_decay * u) >>> 16);
        clin = clamp32((m_conv * u) >>> 16);
        udif = clamp32((m_diff * stencil(1'b0, r, c)) >>> 16);
        vdif = clamp32((m_diff * stencil(1'b1, r, c)) >>> 16);
        res.du_out    = DATA_W'(clamp32(m_feed + uuv - dlin + udif));
        res.dv_out    = DATA_W'(clamp32(clin - uuv + vdif));
        res.cell_row  = CELL_W'(r);
        res.cell_col  = CELL_W'(c);
        res.frame_end = (r == GRID_SIDE - 1) && (c == GRID_SIDE - 1);
        res.run_last  = 1'b0;
        return res;
    endfunction

    // Store one cell and queue the results it releases
    task automatic predict_cell(input in_item_t it);
        out_item_t rel[$];
        u_win[win_slot(m_row, m_col)] = longint'(it.u_in);
        v_win[win_slot(m_row, m_col)] = longint'(it.v_in);
        if (m_row >= 1)
            rel.push_back(cell_rhs(m_row - 1, m_col));
        if (m_row == GRID_SIDE - 1 && m_col >= 1)
            rel.push_back(cell_rhs(m_row, m_col - 1));
        if (m_row == GRID_SIDE - 1 && m_col == GRID_SIDE - 1)
            rel.push_back(cell_rhs(m_row, m_col));
        if (rel.size() > 0)
            rel[rel.size() - 1].run_last = 1'b1;
        foreach (rel[k])
            rhs_q.push_back(rel[k]);
        m_col++;
        if (m_col >= GRID_SIDE)
        begin
            m_col = 0;
            m_row = (m_row + 1 >= GRID_SIDE) ? 0 : m_row + 1;
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_conc();
        if ($urandom_range(0, 9) < 7)
            return DATA_W'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
        return $urandom;
    endfunction

    function automatic int draw_wait();
        if (fast_mode)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Drive cells and mirror accepted ones into the predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_cell(in_item);
                cells_sent++;
                if (cells_sent % 64 == 0)
                    fast_mode = ($urandom_range(0, 3) == 0);
            end
            if (in_valid && !in_ready)
                in_valid <= 1'b1;
            else if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (cell_q.size() > 0)
            begin
                in_item  <= cell_q.pop_front();
                in_valid <= 1'b1;
                in_gap   <= draw_wait();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off so the core backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && cells_sent >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Accept and check result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (out_item.frame_end)
                    frames_seen++;
                if (rhs_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected result row %0d col %0d",
                                 out_item.cell_row, out_item.cell_col);
                end
                else
                begin
                    out_item_t want;
                    want = rhs_q.pop_front();
                    if (want.du_out !== out_item.du_out ||
                        want.dv_out !== out_item.dv_out ||
                        want.cell_row !== out_item.cell_row ||
                        want.cell_col !== out_item.cell_col ||
                        want.frame_end !== out_item.frame_end ||
                        want.run_last !== out_item.run_last)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("ERROR: exp (%0d,%0d) du=%h dv=%h fe=%b rl=%b",
                                     want.cell_row, want.cell_col, want.du_out,
                                     want.dv_out, want.frame_end, want.run_last);
                            $display("       got (%0d,%0d) du=%h dv=%h fe=%b rl=%b",
                                     out_item.cell_row, out_item.cell_col,
                                     out_item.du_out, out_item.dv_out,
                                     out_item.frame_end, out_item.run_last);
                        end
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                out_stall <= draw_wait();
                out_ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (hold_left == 0);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FEED:  m_feed  = longint'(signed'(val));
            REG_DECAY: m_decay = longint'(signed'(val));
            REG_CONV:  m_conv  = longint'(signed'(val));
            default:   m_diff  = longint'(signed'(val));
        endcase
    endtask

    task automatic wait_drained(input int tail);
        @(posedge clk);
        while (cell_q.size() > 0 || in_valid || rhs_q.size() > 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Coefficient setting per phase, extremes included
    function automatic logic [DATA_W-1:0] phase_coeff(input int ph);
        case (ph)
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return '0;
            4:       return $urandom;
            default: return DATA_W'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
        endcase
    endfunction

    initial
    begin
        in_item_t   it;
        logic [DATA_W-1:0] edge_vals[8];
        cfg_valid  = 1'b0;
        cfg_index  = REG_FEED;
        cfg_data   = '0;
        m_feed     = 65536;
        m_decay    = 65536;
        m_conv     = 65536;
        m_diff     = 65536;
        m_row      = 0;
        m_col      = 0;
        fast_mode  = 1'b0;
        cells_sent = 0;
        results_seen = 0;
        frames_seen  = 0;
        err_count    = 0;
        foreach (u_win[k])
        begin
            u_win[k] = 0;
            v_win[k] = 0;
        end
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001};
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cells: field extremes with reset coefficients
        for (int k = 0; k < 25; k++)
        begin
            it.u_in = edge_vals[k % 8];
            it.v_in = edge_vals[(k / 8 + k) % 8];
            cell_q.push_back(it);
        end
        wait_drained(40);

        // Random phases under changing coefficients
        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            write_reg(REG_FEED,  phase_coeff(ph));
            write_reg(REG_DECAY, phase_coeff(ph));
            write_reg(REG_CONV,  phase_coeff(ph));
            write_reg(REG_DIFF,  phase_coeff(ph));
            for (int k = 0; k < RAND_ITEMS; k++)
            begin
                it.u_in = rand_conc();
                it.v_in = rand_conc();
                cell_q.push_back(it);
            end
            wait_drained(40);
        end

        wait_drained(60);
        $display("Covered %0d cells, %0d results, %0d full frames, %0d coefficient phases",
                 cells_sent, results_seen, frames_seen, NUM_PHASES);
        $display("Mismatches counted: %0d", err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
